FILE: rtl/bsc_pkg.sv
// Shared constants, types and helpers for the barometric compensation core.
package bsc_pkg;

    localparam int RAW_W     = 24;
    localparam int ADC_BITS  = 24;
    localparam int COEF_W    = 16;
    localparam int CFG_IDX_W = 3;

    localparam int DT_W   = 26;
    localparam int MP_W   = DT_W + COEF_W + 1;
    localparam int DD_W   = 2 * DT_W;
    localparam int DEV_W  = 22;
    localparam int TEMP_W = 24;
    localparam int SQ_W   = 2 * DEV_W;
    localparam int WIDE_W = 40;
    localparam int SPLIT  = 20;
    localparam int PPL_W  = ADC_BITS + SPLIT;
    localparam int PPH_W  = ADC_BITS + 1 + WIDE_W - SPLIT;
    localparam int PROD_W = ADC_BITS + WIDE_W + 2;
    localparam int OUT_W  = 32;
    localparam int SAT_W  = 48;
    localparam int NSTG   = 10;

    localparam int SH_C5   = 8;
    localparam int SH_C2   = 16;
    localparam int SH_C1   = 15;
    localparam int SH_TEMP = 23;
    localparam int SH_OFF  = 7;
    localparam int SH_SENS = 8;
    localparam int SH_T2   = 31;
    localparam int SH_P1   = 21;
    localparam int SH_P2   = 15;
    localparam int T2_W    = DD_W - SH_T2;
    localparam int Q_W     = PROD_W - SH_P1 + 1;

    localparam int TEMP_LOW  = 2000;
    localparam int TEMP_HIGH = 4500;
    localparam int TEMP_VLOW = -1500;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx REG_SENS        = 3'd0;
    localparam t_cfg_idx REG_OFF         = 3'd1;
    localparam t_cfg_idx REG_SENS_TEMPCO = 3'd2;
    localparam t_cfg_idx REG_OFF_TEMPCO  = 3'd3;
    localparam t_cfg_idx REG_REF_TEMP    = 3'd4;
    localparam t_cfg_idx REG_TEMP_SLOPE  = 3'd5;
    localparam t_cfg_idx REG_SO_ENABLE   = 3'd6;

    function automatic logic signed [OUT_W-1:0] sat32(input logic signed [SAT_W-1:0] x);
        logic signed [SAT_W-1:0] hi_lim;
        logic signed [SAT_W-1:0] lo_lim;
        hi_lim = SAT_W'(64'sh0000_0000_7FFF_FFFF);
        lo_lim = -hi_lim - SAT_W'(1);
        if (x > hi_lim) begin
            sat32 = hi_lim[OUT_W-1:0];
        end else if (x < lo_lim) begin
            sat32 = lo_lim[OUT_W-1:0];
        end else begin
            sat32 = x[OUT_W-1:0];
        end
    endfunction

endpackage

FILE: rtl/baro_sensor_compensation_core.sv
// Pipelined first and second order pressure/temperature compensation core.
//
//   channel  | valid        | ready        | word
//   ---------+--------------+--------------+------------------------------------
//   input    | i_in_valid   | o_in_ready   | i_pressure_raw, i_temperature_raw
//   output   | o_out_valid  | i_out_ready  | o_temperature_centi, o_pressure_comp
//   config   | i_cfg_valid  | o_cfg_ready  | i_cfg_index, i_cfg_data
//
// Ten register stages, the last one the output register: one word per cycle
// sustained while i_out_ready holds. Throughput is set by the four-multiplier
// product stage and the split 24x40 pressure multiply, each one stage wide.
// Each stage keeps its own valid bit; a stage loads when it is empty or the
// one after it moves, so bubbles fill while the output is stalled.
// Synchronous active-low reset clears valid bits and C1..C6 and sets r_so_en.
module baro_sensor_compensation_core (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_in_valid,
    output logic                                    o_in_ready,
    input  logic [bsc_pkg::RAW_W-1:0]               i_pressure_raw,
    input  logic [bsc_pkg::RAW_W-1:0]               i_temperature_raw,
    output logic                                    o_out_valid,
    input  logic                                    i_out_ready,
    output logic signed [bsc_pkg::OUT_W-1:0]        o_temperature_centi,
    output logic signed [bsc_pkg::OUT_W-1:0]        o_pressure_comp,
    input  logic                                    i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  logic [bsc_pkg::CFG_IDX_W-1:0]           i_cfg_index,
    input  logic [bsc_pkg::COEF_W-1:0]              i_cfg_data
);
    import bsc_pkg::*;

    // calibration registers
    logic [COEF_W-1:0] r_c1, r_c2, r_c3, r_c4, r_c5, r_c6;
    logic              r_so_en;

    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] adv;

    // stage 1
    logic [ADC_BITS-1:0]     n_s1_d1;
    logic signed [DT_W-1:0]  n_s1_dt;
    logic [ADC_BITS-1:0]     r_s1_d1;
    logic signed [DT_W-1:0]  r_s1_dt;
    // stage 2
    logic signed [MP_W-1:0]  n_s2_p6, n_s2_p4, n_s2_p3;
    logic signed [DD_W-1:0]  n_s2_pdd;
    logic [ADC_BITS-1:0]     r_s2_d1;
    logic signed [MP_W-1:0]  r_s2_p6, r_s2_p4, r_s2_p3;
    logic signed [DD_W-1:0]  r_s2_pdd;
    // stage 3
    logic signed [DEV_W-1:0]  n_s3_l, n_s3_h, n_s3_v;
    logic signed [TEMP_W-1:0] n_s3_temp;
    logic signed [WIDE_W-1:0] n_s3_off, n_s3_sens;
    logic signed [T2_W-1:0]   n_s3_t2;
    logic                     n_s3_lo, n_s3_hi, n_s3_vlo;
    logic [ADC_BITS-1:0]      r_s3_d1;
    logic signed [DEV_W-1:0]  r_s3_l, r_s3_h, r_s3_v;
    logic signed [TEMP_W-1:0] r_s3_temp;
    logic signed [WIDE_W-1:0] r_s3_off, r_s3_sens;
    logic signed [T2_W-1:0]   r_s3_t2;
    logic                     r_s3_lo, r_s3_hi, r_s3_vlo;
    // stage 4
    logic signed [SQ_W-1:0]   n_s4_sq, n_s4_hsq, n_s4_vsq;
    logic [ADC_BITS-1:0]      r_s4_d1;
    logic signed [TEMP_W-1:0] r_s4_temp;
    logic signed [WIDE_W-1:0] r_s4_off, r_s4_sens;
    logic signed [T2_W-1:0]   r_s4_t2;
    logic                     r_s4_lo, r_s4_hi, r_s4_vlo;
    logic signed [SQ_W-1:0]   r_s4_sq, r_s4_hsq, r_s4_vsq;
    // stage 5
    logic signed [WIDE_W-1:0] sq40, hsq40, vsq40, sq3, sq7;
    logic signed [WIDE_W-1:0] n_s5_off2, n_s5_sens2;
    logic signed [T2_W-1:0]   n_s5_t2;
    logic [ADC_BITS-1:0]      r_s5_d1;
    logic signed [TEMP_W-1:0] r_s5_temp;
    logic signed [WIDE_W-1:0] r_s5_off, r_s5_sens, r_s5_off2, r_s5_sens2;
    logic signed [T2_W-1:0]   r_s5_t2;
    // stage 6
    logic signed [TEMP_W-1:0] n_s6_temp;
    logic signed [WIDE_W-1:0] n_s6_off, n_s6_sens;
    logic [ADC_BITS-1:0]      r_s6_d1;
    logic signed [TEMP_W-1:0] r_s6_temp;
    logic signed [WIDE_W-1:0] r_s6_off, r_s6_sens;
    // stage 7
    logic [PPL_W-1:0]         n_s7_ppl;
    logic signed [PPH_W-1:0]  n_s7_pph;
    logic signed [TEMP_W-1:0] r_s7_temp;
    logic signed [WIDE_W-1:0] r_s7_off;
    logic [PPL_W-1:0]         r_s7_ppl;
    logic signed [PPH_W-1:0]  r_s7_pph;
    // stage 8
    logic signed [PROD_W-1:0] n_s8_prod;
    logic signed [TEMP_W-1:0] r_s8_temp;
    logic signed [WIDE_W-1:0] r_s8_off;
    logic signed [PROD_W-1:0] r_s8_prod;
    // stage 9
    logic signed [Q_W-1:0]    n_s9_q;
    logic signed [TEMP_W-1:0] r_s9_temp;
    logic signed [Q_W-1:0]    r_s9_q;
    // output
    logic signed [SAT_W-1:0]  p_wide;
    logic signed [OUT_W-1:0]  r_out_temp, r_out_pres;

    // configuration
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1    <= '0;
            r_c2    <= '0;
            r_c3    <= '0;
            r_c4    <= '0;
            r_c5    <= '0;
            r_c6    <= '0;
            r_so_en <= 1'b1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_SENS:        r_c1    <= i_cfg_data;
                REG_OFF:         r_c2    <= i_cfg_data;
                REG_SENS_TEMPCO: r_c3    <= i_cfg_data;
                REG_OFF_TEMPCO:  r_c4    <= i_cfg_data;
                REG_REF_TEMP:    r_c5    <= i_cfg_data;
                REG_TEMP_SLOPE:  r_c6    <= i_cfg_data;
                REG_SO_ENABLE:   r_so_en <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // stage advance chain
    always_comb begin
        adv[NSTG-1] = !r_vld[NSTG-1] || i_out_ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            adv[k] = !r_vld[k] || adv[k+1];
        end
    end

    assign o_in_ready = adv[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (adv[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // stage 1: temperature difference
    assign n_s1_d1 = i_pressure_raw[ADC_BITS-1:0];
    assign n_s1_dt = $signed(DT_W'(i_temperature_raw[ADC_BITS-1:0]))
                   - $signed(DT_W'({r_c5, {SH_C5{1'b0}}}));

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r_s1_d1 <= n_s1_d1;
            r_s1_dt <= n_s1_dt;
        end
    end

    // stage 2: products of dT
    assign n_s2_p6  = r_s1_dt * $signed({1'b0, r_c6});
    assign n_s2_p4  = r_s1_dt * $signed({1'b0, r_c4});
    assign n_s2_p3  = r_s1_dt * $signed({1'b0, r_c3});
    assign n_s2_pdd = r_s1_dt * r_s1_dt;

    always_ff @(posedge i_clk) begin
        if (adv[1]) begin
            r_s2_d1  <= r_s1_d1;
            r_s2_p6  <= n_s2_p6;
            r_s2_p4  <= n_s2_p4;
            r_s2_p3  <= n_s2_p3;
            r_s2_pdd <= n_s2_pdd;
        end
    end

    // stage 3: first order terms, region flags
    assign n_s3_l    = DEV_W'(r_s2_p6 >>> SH_TEMP);
    assign n_s3_h    = n_s3_l - DEV_W'(TEMP_HIGH - TEMP_LOW);
    assign n_s3_v    = n_s3_l - DEV_W'(TEMP_VLOW - TEMP_LOW);
    assign n_s3_temp = TEMP_W'(n_s3_l) + TEMP_W'(TEMP_LOW);
    assign n_s3_off  = $signed(WIDE_W'({r_c2, {SH_C2{1'b0}}}))
                     + WIDE_W'(r_s2_p4 >>> SH_OFF);
    assign n_s3_sens = $signed(WIDE_W'({r_c1, {SH_C1{1'b0}}}))
                     + WIDE_W'(r_s2_p3 >>> SH_SENS);
    assign n_s3_t2   = T2_W'(r_s2_pdd >>> SH_T2);
    assign n_s3_lo   = r_so_en && (n_s3_l < DEV_W'(0));
    assign n_s3_hi   = r_so_en && (n_s3_l > DEV_W'(TEMP_HIGH - TEMP_LOW));
    assign n_s3_vlo  = n_s3_l < DEV_W'(TEMP_VLOW - TEMP_LOW);

    always_ff @(posedge i_clk) begin
        if (adv[2]) begin
            r_s3_d1   <= r_s2_d1;
            r_s3_l    <= n_s3_l;
            r_s3_h    <= n_s3_h;
            r_s3_v    <= n_s3_v;
            r_s3_temp <= n_s3_temp;
            r_s3_off  <= n_s3_off;
            r_s3_sens <= n_s3_sens;
            r_s3_t2   <= n_s3_t2;
            r_s3_lo   <= n_s3_lo;
            r_s3_hi   <= n_s3_hi;
            r_s3_vlo  <= n_s3_vlo;
        end
    end

    // stage 4: squares
    assign n_s4_sq  = r_s3_l * r_s3_l;
    assign n_s4_hsq = r_s3_h * r_s3_h;
    assign n_s4_vsq = r_s3_v * r_s3_v;

    always_ff @(posedge i_clk) begin
        if (adv[3]) begin
            r_s4_d1   <= r_s3_d1;
            r_s4_temp <= r_s3_temp;
            r_s4_off  <= r_s3_off;
            r_s4_sens <= r_s3_sens;
            r_s4_t2   <= r_s3_t2;
            r_s4_lo   <= r_s3_lo;
            r_s4_hi   <= r_s3_hi;
            r_s4_vlo  <= r_s3_vlo;
            r_s4_sq   <= n_s4_sq;
            r_s4_hsq  <= n_s4_hsq;
            r_s4_vsq  <= n_s4_vsq;
        end
    end

    // stage 5: second order corrections
    assign sq40  = WIDE_W'(r_s4_sq);
    assign hsq40 = WIDE_W'(r_s4_hsq);
    assign vsq40 = WIDE_W'(r_s4_vsq);
    assign sq3   = (sq40 <<< 1) + sq40;
    assign sq7   = (sq40 <<< 3) - sq40;

    always_comb begin
        n_s5_off2  = '0;
        n_s5_sens2 = '0;
        n_s5_t2    = '0;
        if (r_s4_lo) begin
            n_s5_off2  = sq3;
            n_s5_sens2 = (sq7 >>> 3) + (r_s4_vlo ? (vsq40 <<< 1) : WIDE_W'(0));
            n_s5_t2    = r_s4_t2;
        end else if (r_s4_hi) begin
            n_s5_sens2 = -(hsq40 >>> 3);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[4]) begin
            r_s5_d1    <= r_s4_d1;
            r_s5_temp  <= r_s4_temp;
            r_s5_off   <= r_s4_off;
            r_s5_sens  <= r_s4_sens;
            r_s5_off2  <= n_s5_off2;
            r_s5_sens2 <= n_s5_sens2;
            r_s5_t2    <= n_s5_t2;
        end
    end

    // stage 6: apply corrections
    assign n_s6_temp = r_s5_temp - TEMP_W'(r_s5_t2);
    assign n_s6_off  = r_s5_off - r_s5_off2;
    assign n_s6_sens = r_s5_sens - r_s5_sens2;

    always_ff @(posedge i_clk) begin
        if (adv[5]) begin
            r_s6_d1   <= r_s5_d1;
            r_s6_temp <= n_s6_temp;
            r_s6_off  <= n_s6_off;
            r_s6_sens <= n_s6_sens;
        end
    end

    // stage 7: D1 * SENS as two partial products
    assign n_s7_ppl = r_s6_d1 * r_s6_sens[SPLIT-1:0];
    assign n_s7_pph = $signed({1'b0, r_s6_d1}) * $signed(r_s6_sens[WIDE_W-1:SPLIT]);

    always_ff @(posedge i_clk) begin
        if (adv[6]) begin
            r_s7_temp <= r_s6_temp;
            r_s7_off  <= r_s6_off;
            r_s7_ppl  <= n_s7_ppl;
            r_s7_pph  <= n_s7_pph;
        end
    end

    // stage 8: combine partial products
    assign n_s8_prod = (PROD_W'(r_s7_pph) <<< SPLIT) + PROD_W'($signed({1'b0, r_s7_ppl}));

    always_ff @(posedge i_clk) begin
        if (adv[7]) begin
            r_s8_temp <= r_s7_temp;
            r_s8_off  <= r_s7_off;
            r_s8_prod <= n_s8_prod;
        end
    end

    // stage 9: subtract offset
    assign n_s9_q = Q_W'(r_s8_prod >>> SH_P1) - Q_W'(r_s8_off);

    always_ff @(posedge i_clk) begin
        if (adv[8]) begin
            r_s9_temp <= r_s8_temp;
            r_s9_q    <= n_s9_q;
        end
    end

    // output register: final shift and clamp
    assign p_wide = SAT_W'(r_s9_q >>> SH_P2);

    always_ff @(posedge i_clk) begin
        if (adv[9]) begin
            r_out_temp <= sat32(SAT_W'(r_s9_temp));
            r_out_pres <= sat32(p_wide);
        end
    end

    assign o_out_valid         = r_vld[NSTG-1];
    assign o_temperature_centi = r_out_temp;
    assign o_pressure_comp     = r_out_pres;

    // checks
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    a_full_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (&r_vld && !i_out_ready) |-> !o_in_ready)
        else $error("input taken while pipeline full and stalled");

    a_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[3] && !adv[3]) |=> (r_vld[3] && $stable(r_s4_sq) && $stable(r_s4_sens)))
        else $error("stalled stage lost or changed its word");

    a_region_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[2] |-> !(r_s3_lo && r_s3_hi))
        else $error("low and high temperature branches both selected");

endmodule
